@@ rtl/radix_page_table_builder_core_macros.svh @@
// ----------------------------------------------------------------------------
// Radix page table builder assertion macros
// Concurrent assertion wrappers, empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef RADIX_PAGE_TABLE_BUILDER_CORE_MACROS_SVH
`define RADIX_PAGE_TABLE_BUILDER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// checked at every edge outside reset
`define RPTB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define RPTB_ASSERT_NORST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPTB_ASSERT(lbl, clk, rst, prop, msg)
`define RPTB_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/rptb_pkg.sv @@
// ----------------------------------------------------------------------------
// Radix page table builder package
// Field widths, register codes, controller states and command/status types.
// ----------------------------------------------------------------------------
package rptb_pkg;

   // item field widths
   localparam int VP_W        = 36;
   localparam int PP_W        = 40;
   localparam int BASE_W      = 40;
   localparam int FLAG_W      = 12;
   localparam int OFF_W       = 18;
   localparam int ENTRY_W     = 64;
   localparam int USED_W      = 19;
   localparam int IDX_W       = 9;
   localparam int FRAME_OFS_W = 12;
   localparam int MAX_LEVELS  = 5;
   localparam int LVL_W       = 3;

   // register port
   localparam int APB_AW = 5;
   localparam int APB_DW = 64;

   typedef enum logic [1:0] {
      CSR_TABLE_BASE  = 2'd0,
      CSR_DIR_FLAGS   = 2'd1,
      CSR_LEAF_FLAGS  = 2'd2
   } csr_index_type;

   localparam logic [BASE_W-1:0] TABLE_BASE_RST = '0;
   localparam logic [FLAG_W-1:0] DIR_FLAGS_RST  = 12'd11;
   localparam logic [FLAG_W-1:0] LEAF_FLAGS_RST = 12'd3;

   // request kinds
   localparam logic REQ_START   = 1'b0;
   localparam logic REQ_INSTALL = 1'b1;

   typedef enum logic [3:0] {
      ST_INIT_CLR,
      ST_IDLE,
      ST_START_CLR,
      ST_START_RSP,
      ST_P1_RD,
      ST_P1_CHK,
      ST_CAP,
      ST_P2_RD,
      ST_P2_CHK,
      ST_LEAF,
      ST_ERR
   } state_type;

   typedef struct packed {
      logic load_req;
      logic rd_issue;
      logic p1_zero;
      logic p1_follow;
      logic p2_restart;
      logic p2_alloc;
      logic p2_follow;
      logic leaf_write;
      logic emit_err;
      logic emit_start;
      logic clr_step;
      logic clr_end;
   } ctrl_cmd_type;

   typedef struct packed {
      logic rd_zero;
      logic child_ok;
      logic lvl_two;
      logic cap_ok;
      logic clear_done;
      logic out_free;
   } dp_status_type;

   // 9-bit table index of a virtual page at a given level (level 1 is the leaf)
   function automatic logic [IDX_W-1:0] slice_index(input logic [VP_W-1:0]  vp,
                                                    input logic [LVL_W-1:0] lvl);
      logic [MAX_LEVELS*IDX_W-1:0] ext;
      logic [IDX_W-1:0]            res;
      ext = (MAX_LEVELS*IDX_W)'(vp);
      res = '0;
      for (int l = 1; l <= MAX_LEVELS; l++) begin
         if (lvl == LVL_W'(l)) begin
            res = ext[IDX_W*(l-1) +: IDX_W];
         end
      end
      return res;
   endfunction

endpackage

@@ rtl/rptb_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one build request item.
// ----------------------------------------------------------------------------
interface rptb_req_if;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic [rptb_pkg::VP_W-1:0]   virt_page;
   logic [rptb_pkg::PP_W-1:0]   phys_page;

   modport source (output valid, req_type, virt_page, phys_page, input ready);
   modport sink   (input valid, req_type, virt_page, phys_page, output ready);
endinterface

@@ rtl/rptb_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one entry write or status item.
// ----------------------------------------------------------------------------
interface rptb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rptb_pkg::OFF_W-1:0]    write_offset;
   logic [rptb_pkg::ENTRY_W-1:0]  entry_value;
   logic                          status;
   logic [rptb_pkg::USED_W-1:0]   used_bytes;
   logic                          last;

   modport source (output valid, write_offset, entry_value, status, used_bytes, last,
                   input ready);
   modport sink   (input valid, write_offset, entry_value, status, used_bytes, last,
                   output ready);
endinterface

@@ rtl/rptb_csr.sv @@
// ----------------------------------------------------------------------------
// Register block
// APB-style configuration registers: table base page and entry flags.
// ----------------------------------------------------------------------------
module rptb_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rptb_pkg::APB_AW-1:0]   paddr,
   input  logic [rptb_pkg::APB_DW-1:0]   pwdata,
   output logic [rptb_pkg::APB_DW-1:0]   prdata,
   output logic                          pready,
   output logic [rptb_pkg::BASE_W-1:0]   table_base_page,
   output logic [rptb_pkg::FLAG_W-1:0]   directory_flags,
   output logic [rptb_pkg::FLAG_W-1:0]   leaf_flags
);

   logic [rptb_pkg::BASE_W-1:0] base_ff,  base_in;
   logic [rptb_pkg::FLAG_W-1:0] dflag_ff, dflag_in;
   logic [rptb_pkg::FLAG_W-1:0] lflag_ff, lflag_in;
   logic                        wr_en;
   rptb_pkg::csr_index_type     reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   // registers sit on 8-byte boundaries
   assign reg_idx = rptb_pkg::csr_index_type'(paddr[4:3]);

   // write decode
   always_comb begin
      base_in  = base_ff;
      dflag_in = dflag_ff;
      lflag_in = lflag_ff;
      if (wr_en) begin
         unique case (reg_idx)
            rptb_pkg::CSR_TABLE_BASE: base_in  = pwdata[rptb_pkg::BASE_W-1:0];
            rptb_pkg::CSR_DIR_FLAGS:  dflag_in = pwdata[rptb_pkg::FLAG_W-1:0];
            rptb_pkg::CSR_LEAF_FLAGS: lflag_in = pwdata[rptb_pkg::FLAG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= rptb_pkg::TABLE_BASE_RST;
         dflag_ff <= rptb_pkg::DIR_FLAGS_RST;
         lflag_ff <= rptb_pkg::LEAF_FLAGS_RST;
      end else begin
         base_ff  <= base_in;
         dflag_ff <= dflag_in;
         lflag_ff <= lflag_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         rptb_pkg::CSR_TABLE_BASE: prdata = rptb_pkg::APB_DW'(base_ff);
         rptb_pkg::CSR_DIR_FLAGS:  prdata = rptb_pkg::APB_DW'(dflag_ff);
         rptb_pkg::CSR_LEAF_FLAGS: prdata = rptb_pkg::APB_DW'(lflag_ff);
         default:                  prdata = '0;
      endcase
   end

   assign table_base_page = base_ff;
   assign directory_flags = dflag_ff;
   assign leaf_flags      = lflag_ff;

endmodule

@@ rtl/rptb_ctrl.sv @@
// ----------------------------------------------------------------------------
// Builder controller
// Sequences store clearing, the checking walk, the writing walk and results.
// ----------------------------------------------------------------------------
`include "radix_page_table_builder_core_macros.svh"

module rptb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_type,
   output logic                    req_ready,
   input  rptb_pkg::dp_status_type stat,
   output rptb_pkg::ctrl_cmd_type  cmd
);

   rptb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rptb_pkg::ST_INIT_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         rptb_pkg::ST_INIT_CLR: begin
            if (stat.clear_done) begin
               cmd.clr_end = 1'b1;
               state_in    = rptb_pkg::ST_IDLE;
            end else begin
               cmd.clr_step = 1'b1;
            end
         end
         rptb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = (req_type == rptb_pkg::REQ_START) ? rptb_pkg::ST_START_CLR
                                                                : rptb_pkg::ST_P1_RD;
            end
         end
         rptb_pkg::ST_START_CLR: begin
            if (stat.clear_done) begin
               cmd.clr_end = 1'b1;
               state_in    = rptb_pkg::ST_START_RSP;
            end else begin
               cmd.clr_step = 1'b1;
            end
         end
         rptb_pkg::ST_START_RSP: begin
            if (stat.out_free) begin
               cmd.emit_start = 1'b1;
               state_in       = rptb_pkg::ST_IDLE;
            end
         end
         // checking walk: find the first empty directory entry
         rptb_pkg::ST_P1_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = rptb_pkg::ST_P1_CHK;
         end
         rptb_pkg::ST_P1_CHK: begin
            priority if (stat.rd_zero) begin
               cmd.p1_zero = 1'b1;
               state_in    = rptb_pkg::ST_CAP;
            end else if (!stat.child_ok) begin
               state_in = rptb_pkg::ST_ERR;
            end else begin
               cmd.p1_follow = 1'b1;
               state_in      = stat.lvl_two ? rptb_pkg::ST_CAP : rptb_pkg::ST_P1_RD;
            end
         end
         rptb_pkg::ST_CAP: begin
            if (stat.cap_ok) begin
               cmd.p2_restart = 1'b1;
               state_in       = rptb_pkg::ST_P2_RD;
            end else begin
               state_in = rptb_pkg::ST_ERR;
            end
         end
         // writing walk: allocate missing directories
         rptb_pkg::ST_P2_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = rptb_pkg::ST_P2_CHK;
         end
         rptb_pkg::ST_P2_CHK: begin
            if (stat.rd_zero) begin
               if (stat.out_free) begin
                  cmd.p2_alloc = 1'b1;
                  state_in     = stat.lvl_two ? rptb_pkg::ST_LEAF : rptb_pkg::ST_P2_RD;
               end
            end else begin
               cmd.p2_follow = 1'b1;
               state_in      = stat.lvl_two ? rptb_pkg::ST_LEAF : rptb_pkg::ST_P2_RD;
            end
         end
         rptb_pkg::ST_LEAF: begin
            if (stat.out_free) begin
               cmd.leaf_write = 1'b1;
               state_in       = rptb_pkg::ST_IDLE;
            end
         end
         rptb_pkg::ST_ERR: begin
            if (stat.out_free) begin
               cmd.emit_err = 1'b1;
               state_in     = rptb_pkg::ST_IDLE;
            end
         end
         default: state_in = rptb_pkg::ST_IDLE;
      endcase
   end

   // every accepted item takes the controller out of idle
   `RPTB_ASSERT(a_acc_leaves_idle, clock, reset, (state_ff == rptb_pkg::ST_IDLE && req_valid) |=> (state_ff != rptb_pkg::ST_IDLE), "accepted item did not start")
   // check state always sees data from the read just issued
   `RPTB_ASSERT(a_p1_read_fresh, clock, reset, (state_ff == rptb_pkg::ST_P1_CHK) |-> ($past(state_ff) == rptb_pkg::ST_P1_RD), "walk check without read")
   // error result only follows a failed check
   `RPTB_ASSERT(a_err_source, clock, reset, (state_ff == rptb_pkg::ST_ERR) |-> ($past(state_ff) == rptb_pkg::ST_CAP || $past(state_ff) == rptb_pkg::ST_P1_CHK || $past(state_ff) == rptb_pkg::ST_ERR), "unexpected entry to error state")

endmodule

@@ rtl/rptb_dp.sv @@
// ----------------------------------------------------------------------------
// Builder datapath
// Table store, walk registers, page allocator, clear sweep and result register.
// ----------------------------------------------------------------------------
`include "radix_page_table_builder_core_macros.svh"

module rptb_dp #(
   parameter int TABLE_PAGES = 64,
   parameter int LEVELS      = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rptb_pkg::ctrl_cmd_type        cmd,
   output rptb_pkg::dp_status_type       stat,
   input  logic [rptb_pkg::VP_W-1:0]     in_virt_page,
   input  logic [rptb_pkg::PP_W-1:0]     in_phys_page,
   input  logic [rptb_pkg::BASE_W-1:0]   table_base_page,
   input  logic [rptb_pkg::FLAG_W-1:0]   directory_flags,
   input  logic [rptb_pkg::FLAG_W-1:0]   leaf_flags,
   rptb_rsp_if.source                    rsp_chan
);

   localparam int PW    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
   localparam int NW    = $clog2(TABLE_PAGES + 1);
   localparam int AW    = PW + rptb_pkg::IDX_W;
   localparam int CW    = NW + rptb_pkg::IDX_W;
   localparam int DEPTH = TABLE_PAGES * (2 ** rptb_pkg::IDX_W);
   localparam int EW    = rptb_pkg::ENTRY_W;
   localparam int PTR_W = EW - rptb_pkg::FRAME_OFS_W;
   localparam logic [rptb_pkg::LVL_W-1:0] TOP_LEVEL = rptb_pkg::LVL_W'(LEVELS);

   // walk registers
   logic [rptb_pkg::VP_W-1:0]  vp_ff,    vp_in;
   logic [rptb_pkg::PP_W-1:0]  pp_ff,    pp_in;
   logic [PW-1:0]              page_ff,  page_in;
   logic [rptb_pkg::LVL_W-1:0] lvl_ff,   lvl_in;
   logic [rptb_pkg::LVL_W-1:0] need_ff,  need_in;
   logic [NW-1:0]              nfp_ff,   nfp_in;
   logic [NW-1:0]              dirty_ff, dirty_in;
   logic [CW-1:0]              clr_ff,   clr_in;
   logic [EW-1:0]              rd_data_ff;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [rptb_pkg::OFF_W-1:0] off_ff,   off_in;
   logic [EW-1:0]              val_ff,   val_in;
   logic                       stat_ff,  stat_in;
   logic [rptb_pkg::USED_W-1:0] used_ff;
   logic                       last_ff,  last_in;

   logic [EW-1:0]              store_mem [DEPTH];

   logic [rptb_pkg::IDX_W-1:0] idx;
   logic [AW-1:0]              slot;
   logic [PTR_W:0]             child_diff;
   logic                       child_ok;
   logic [PW-1:0]              child_page;
   logic [NW:0]                cap_sum;
   logic [CW-1:0]              clr_limit;
   logic [rptb_pkg::BASE_W:0]  dir_sum;
   logic [EW-1:0]              dir_entry;
   logic [EW-1:0]              leaf_entry;
   logic [NW-1:0]              page_plus;
   logic                       mem_we;
   logic [AW-1:0]              mem_waddr;
   logic [EW-1:0]              mem_wdata;
   logic                       out_load;
   logic                       out_free;

   // entry address and derived values
   assign idx        = rptb_pkg::slice_index(vp_ff, lvl_ff);
   assign slot       = {page_ff, idx};
   assign child_diff = {1'b0, rd_data_ff[EW-1:rptb_pkg::FRAME_OFS_W]}
                       - (PTR_W+1)'(table_base_page);
   assign child_ok   = !child_diff[PTR_W] && (child_diff[PTR_W-1:0] < PTR_W'(TABLE_PAGES));
   assign child_page = child_ok ? child_diff[PW-1:0] : '0;
   assign cap_sum    = {1'b0, nfp_ff} + (NW+1)'(need_ff);
   assign clr_limit  = {dirty_ff, {rptb_pkg::IDX_W{1'b0}}};
   assign dir_sum    = {1'b0, table_base_page} + (rptb_pkg::BASE_W+1)'(nfp_ff);
   assign dir_entry  = (EW'(dir_sum) << rptb_pkg::FRAME_OFS_W) | EW'(directory_flags);
   assign leaf_entry = (EW'(pp_ff) << rptb_pkg::FRAME_OFS_W) | EW'(leaf_flags);
   assign page_plus  = NW'(page_ff) + NW'(1);

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign out_load = cmd.p2_alloc | cmd.leaf_write | cmd.emit_err | cmd.emit_start;

   // status to controller
   assign stat.rd_zero    = (rd_data_ff == '0);
   assign stat.child_ok   = child_ok;
   assign stat.lvl_two    = (lvl_ff == rptb_pkg::LVL_W'(2));
   assign stat.cap_ok     = (cap_sum <= (NW+1)'(TABLE_PAGES));
   assign stat.clear_done = (clr_ff == clr_limit);
   assign stat.out_free   = out_free;

   // walk, allocator and sweep updates
   always_comb begin
      vp_in    = vp_ff;
      pp_in    = pp_ff;
      page_in  = page_ff;
      lvl_in   = lvl_ff;
      need_in  = need_ff;
      nfp_in   = nfp_ff;
      dirty_in = dirty_ff;
      clr_in   = clr_ff;
      if (cmd.load_req) begin
         vp_in   = in_virt_page;
         pp_in   = in_phys_page;
         page_in = '0;
         lvl_in  = TOP_LEVEL;
         need_in = '0;
      end
      if (cmd.p1_zero) begin
         need_in = lvl_ff - rptb_pkg::LVL_W'(1);
      end
      if (cmd.p1_follow || cmd.p2_follow) begin
         page_in = child_page;
         lvl_in  = lvl_ff - rptb_pkg::LVL_W'(1);
      end
      if (cmd.p2_restart) begin
         page_in = '0;
         lvl_in  = TOP_LEVEL;
      end
      if (cmd.p2_alloc) begin
         page_in = PW'(nfp_ff);
         lvl_in  = lvl_ff - rptb_pkg::LVL_W'(1);
         nfp_in  = nfp_ff + NW'(1);
      end
      if (cmd.emit_start) begin
         nfp_in = NW'(1);
      end
      // track the highest page written since the last clear so a start clears only those
      if ((cmd.p2_alloc || cmd.leaf_write) && (page_plus > dirty_ff)) begin
         dirty_in = page_plus;
      end
      if (cmd.clr_step) begin
         clr_in = clr_ff + CW'(1);
      end
      if (cmd.clr_end) begin
         clr_in   = '0;
         dirty_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff  <= '0;
         lvl_ff   <= '0;
         need_ff  <= '0;
         nfp_ff   <= NW'(1);
         dirty_ff <= NW'(TABLE_PAGES);
         clr_ff   <= '0;
      end else begin
         page_ff  <= page_in;
         lvl_ff   <= lvl_in;
         need_ff  <= need_in;
         nfp_ff   <= nfp_in;
         dirty_ff <= dirty_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      vp_ff <= vp_in;
      pp_ff <= pp_in;
   end

   // table store: one write and one registered read per cycle
   assign mem_we    = cmd.clr_step | cmd.p2_alloc | cmd.leaf_write;
   assign mem_waddr = cmd.clr_step ? clr_ff[AW-1:0] : slot;
   assign mem_wdata = cmd.clr_step ? '0 : (cmd.p2_alloc ? dir_entry : leaf_entry);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= store_mem[slot];
      end
   end

   // result payload
   always_comb begin
      off_in  = '0;
      val_in  = '0;
      stat_in = 1'b0;
      last_in = 1'b1;
      priority if (cmd.p2_alloc) begin
         off_in  = rptb_pkg::OFF_W'({slot, 3'b000});
         val_in  = dir_entry;
         last_in = 1'b0;
      end else if (cmd.leaf_write) begin
         off_in  = rptb_pkg::OFF_W'({slot, 3'b000});
         val_in  = leaf_entry;
      end else if (cmd.emit_err) begin
         stat_in = 1'b1;
      end else begin
         stat_in = 1'b0;
      end
   end

   assign rsp_valid_in = out_load | (rsp_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         off_ff  <= off_in;
         val_ff  <= val_in;
         stat_ff <= stat_in;
         used_ff <= rptb_pkg::USED_W'({nfp_in, 12'h000});
         last_ff <= last_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.write_offset = off_ff;
   assign rsp_chan.entry_value  = val_ff;
   assign rsp_chan.status       = stat_ff;
   assign rsp_chan.used_bytes   = used_ff;
   assign rsp_chan.last         = last_ff;

   // a result is only loaded when the register has room
   `RPTB_ASSERT(a_out_room, clock, reset, out_load |-> out_free, "result register overrun")
   // capacity check keeps allocation inside the store
   `RPTB_ASSERT(a_alloc_in_range, clock, reset, cmd.p2_alloc |=> (nfp_ff != '0 && nfp_ff <= NW'(TABLE_PAGES)), "page allocation past store end")
   // the sweep never runs past the dirty region
   `RPTB_ASSERT(a_clear_bound, clock, reset, cmd.clr_step |-> !stat.clear_done, "clear sweep overran")
   `RPTB_ASSERT_NORST(a_reset_idle, clock, reset |=> !rsp_valid_ff, "result valid after reset")

endmodule

@@ rtl/radix_page_table_builder_core.sv @@
// Install: a checking walk (a read state and a check state per level, down to level 2), a
// capacity check, a writing walk that allocates missing directories, and a leaf write.
// Start: every store entry of every page written since the last clear is swept, then a status item.
// The table store has one write port and one registered read port; a new item is taken only in idle.
// Reset is synchronous; afterwards all TABLE_PAGES*512 entries are swept to zero before the
// first item is taken, while register writes are accepted throughout.
// ----------------------------------------------------------------------------
// Radix page table builder
// Top level: register block, walk controller and table store datapath.
// ----------------------------------------------------------------------------
module radix_page_table_builder_core #(
   parameter int TABLE_PAGES = 64,
   parameter int LEVELS      = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   rptb_req_if.sink                      req_chan,
   rptb_rsp_if.source                    rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rptb_pkg::APB_AW-1:0]   paddr,
   input  logic [rptb_pkg::APB_DW-1:0]   pwdata,
   output logic [rptb_pkg::APB_DW-1:0]   prdata,
   output logic                          pready
);

   logic [rptb_pkg::BASE_W-1:0] table_base_page;
   logic [rptb_pkg::FLAG_W-1:0] directory_flags;
   logic [rptb_pkg::FLAG_W-1:0] leaf_flags;
   rptb_pkg::ctrl_cmd_type      cmd;
   rptb_pkg::dp_status_type     stat;

   // configuration registers
   rptb_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .table_base_page (table_base_page),
      .directory_flags (directory_flags),
      .leaf_flags      (leaf_flags)
   );

   // walk sequencer
   rptb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // store and result path
   rptb_dp #(
      .TABLE_PAGES (TABLE_PAGES),
      .LEVELS      (LEVELS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .in_virt_page    (req_chan.virt_page),
      .in_phys_page    (req_chan.phys_page),
      .table_base_page (table_base_page),
      .directory_flags (directory_flags),
      .leaf_flags      (leaf_flags),
      .rsp_chan        (rsp_chan)
   );

endmodule
